// ----- rtl/ip_host_classify_and_learn_macros.svh -----
// Assertion macros for the IP host classifier.
`ifndef IP_HOST_CLASSIFY_AND_LEARN_MACROS_SVH
`define IP_HOST_CLASSIFY_AND_LEARN_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low.
`define IHCL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ihcl: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off while reset is low.
`define IHCL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ihcl: next-cycle check failed");

`endif

// ----- rtl/ihcl_pkg.sv -----
// Shared types and constants of the IP host classifier.
`default_nettype none

package ihcl_pkg;

    typedef logic [2:0] t_kind;

    localparam t_kind KIND_EXTERNAL = 3'd0;
    localparam t_kind KIND_SINK     = 3'd1;
    localparam t_kind KIND_KNOWN    = 3'd2;
    localparam t_kind KIND_ADDED    = 3'd3;
    localparam t_kind KIND_FULL     = 3'd4;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK = 2'd1;

    localparam logic [31:0] SSDP_GROUP        = (32'd239 << 0) + (32'd255 << 8)
                                              + (32'd255 << 16) + (32'd250 << 24);
    localparam logic [31:0] FIRST_OCTET_MASK  = 32'h0000_00FF;
    localparam logic [31:0] MCAST_FIRST_OCTET = 32'd224;
    localparam logic [31:0] BROADCAST_ALL     = 32'hFFFF_FFFF;

    // Job handed from the classifier to the scan sequencer.
    typedef struct packed {
        logic        go;
        logic        direct;
        t_kind       kind;
        logic        add;
        logic [31:0] addr;
    } t_req;

    // Result word.
    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [5:0] idx;
    } t_rsp;

endpackage

`default_nettype wire

// ----- rtl/ip_host_classify_and_learn.sv -----
// Top level: IPv4 host classifier with a learning host table.
//
//   channel   | signals                                   | dir | flow
//   ----------+-------------------------------------------+-----+---------------------------
//   command   | start, busy, i_cmd, i_address             | in  | taken when start & !busy
//   result    | o_valid, o_kind, o_entry_index            | out | one-cycle strobe, no stall
//   config    | i_cfg_we, i_cfg_idx, i_cfg_data           | in  | written when i_cfg_we
//
// Flow: an address settled by classification alone (external, or multicast
// on an add) shows its result in the cycle after the accept. Otherwise the
// table is scanned entry by entry through one comparator fed by the single
// memory read port, and the result shows once a hit is found or every stored
// host has been compared.
// Reset: synchronous, active low; clears the config registers, the sequencer
// and the host count. Table contents stay as they were and are never read
// above the count, so no clearing pass.
// Stalls: busy stays high during a scan; the result strobe cannot be held.
`default_nettype none

`include "ip_host_classify_and_learn_macros.svh"

module ip_host_classify_and_learn #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // command word
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cmd,
    input  wire logic [31:0]                   i_address,
    // result word
    output logic                               o_valid,
    output ihcl_pkg::t_kind                    o_kind,
    output logic [5:0]                         o_entry_index,
    // config port
    input  wire logic                          i_cfg_we,
    input  wire logic [ihcl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]                   i_cfg_data
);

    import ihcl_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [31:0] r_own_address;
    logic [31:0] r_subnet_mask;

    // config registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= '0;
            r_subnet_mask <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OWN_ADDRESS: r_own_address <= i_cfg_data;
                CFG_SUBNET_MASK: r_subnet_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // classification of the incoming address
    logic in_subnet;
    logic is_mcast;
    t_req req;

    assign in_subnet = (r_subnet_mask & r_own_address) == (r_subnet_mask & i_address);
    assign is_mcast  = (i_address == SSDP_GROUP)
                    || ((i_address & FIRST_OCTET_MASK) == MCAST_FIRST_OCTET)
                    || (i_address == BROADCAST_ALL);

    always_comb begin
        req.go   = start && !busy;
        req.add  = i_cmd;
        req.addr = i_address;
        if (!i_cmd) begin
            // lookup: only external skips the scan
            req.direct = !in_subnet && !is_mcast;
            req.kind   = KIND_EXTERNAL;
        end else begin
            // add: outside subnet is external, multicast inside it is a sink
            req.direct = !in_subnet || is_mcast;
            req.kind   = in_subnet ? KIND_SINK : KIND_EXTERNAL;
        end
    end

    t_rsp          rsp;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [31:0]   rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_data;

    ihcl_seq #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .CW         (CW),
        .IW         (IW)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .o_busy   (busy),
        .o_rsp    (rsp),
        .o_rd_en  (rd_en),
        .o_rd_addr(rd_addr),
        .i_rd_data(rd_data),
        .o_wr_en  (wr_en),
        .o_wr_addr(wr_addr),
        .o_wr_data(wr_data)
    );

    ihcl_table #(
        .DEPTH(TABLE_DEPTH),
        .IW   (IW)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign o_valid       = rsp.valid;
    assign o_kind        = rsp.kind;
    assign o_entry_index = rsp.idx;

    // kinds that name no table entry
    logic hostless_kind;
    assign hostless_kind = (o_kind == KIND_EXTERNAL) || (o_kind == KIND_SINK)
                        || (o_kind == KIND_FULL);

    // an accepted word either answers at once or keeps the block busy
    `IHCL_ASSERT_NEXT(a_accept_progress, start && !busy, busy || o_valid)
    // results come out only once the sequencer is back in idle
    `IHCL_ASSERT_NOW(a_result_idle, o_valid, !busy)
    // non-host kinds carry a zero index
    `IHCL_ASSERT_NOW(a_zero_index, o_valid && hostless_kind, o_entry_index == 6'd0)
    // a direct classification answers in the very next cycle
    `IHCL_ASSERT_NEXT(a_direct_answer, req.go && req.direct, o_valid && !busy)

endmodule

`default_nettype wire

// ----- rtl/ihcl_table.sv -----
// Host table memory: one write port, one registered read port.
`default_nettype none

module ihcl_table #(
    parameter int DEPTH = 64,
    parameter int IW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [IW-1:0] i_wr_addr,
    input  wire logic [31:0]   i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [IW-1:0] i_rd_addr,
    output logic      [31:0]   o_rd_data
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/ihcl_seq.sv -----
// Scan sequencer: walks the host table through one comparator, appends new hosts.
`default_nettype none

module ihcl_seq #(
    parameter int TABLE_DEPTH = 64,
    parameter int CW          = 7,
    parameter int IW          = 6
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  ihcl_pkg::t_req      i_req,
    output logic                o_busy,
    output ihcl_pkg::t_rsp      o_rsp,
    output logic                o_rd_en,
    output logic [IW-1:0]       o_rd_addr,
    input  wire logic [31:0]    i_rd_data,
    output logic                o_wr_en,
    output logic [IW-1:0]       o_wr_addr,
    output logic [31:0]         o_wr_data
);

    import ihcl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state      r_state, n_state;
    logic        r_valid, n_valid;
    logic        r_pend,  n_pend;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr,   n_ptr;
    logic        r_add,   n_add;
    logic [31:0] r_addr,  n_addr;
    t_kind       r_kind,  n_kind;
    logic [5:0]  r_idx,   n_idx;

    logic          hit;
    logic [CW-1:0] hit_idx;

    assign hit     = r_pend && (i_rd_data == r_addr);
    assign hit_idx = r_ptr - CW'(1);

    always_comb begin
        n_state   = r_state;
        n_valid   = 1'b0;
        n_pend    = 1'b0;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_add     = r_add;
        n_addr    = r_addr;
        n_kind    = r_kind;
        n_idx     = r_idx;
        o_rd_en   = 1'b0;
        o_rd_addr = r_ptr[IW-1:0];
        o_wr_en   = 1'b0;
        o_wr_addr = r_count[IW-1:0];
        o_wr_data = r_addr;
        case (r_state)
            S_IDLE: begin
                if (i_req.go) begin
                    n_add  = i_req.add;
                    n_addr = i_req.addr;
                    n_ptr  = '0;
                    if (i_req.direct) begin
                        n_valid = 1'b1;
                        n_kind  = i_req.kind;
                        n_idx   = '0;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_valid = 1'b1;
                    n_kind  = KIND_KNOWN;
                    n_idx   = 6'(hit_idx);
                    n_state = S_IDLE;
                end else if (r_ptr == r_count) begin
                    // all valid entries compared, no match
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    n_idx   = '0;
                    if (!r_add) begin
                        n_kind = KIND_SINK;
                    end else if (r_count < CW'(TABLE_DEPTH)) begin
                        o_wr_en = 1'b1;
                        n_kind  = KIND_ADDED;
                        n_idx   = 6'(r_count);
                        n_count = r_count + CW'(1);
                    end else begin
                        n_kind = KIND_FULL;
                    end
                end else begin
                    o_rd_en = 1'b1;
                    n_ptr   = r_ptr + CW'(1);
                    n_pend  = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_pend  <= n_pend;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_add  <= n_add;
        r_addr <= n_addr;
        r_kind <= n_kind;
        r_idx  <= n_idx;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_rsp.valid = r_valid;
    assign o_rsp.kind  = r_kind;
    assign o_rsp.idx   = r_idx;

endmodule

`default_nettype wire
